/* hw/rtl/serial_line_assembler_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the serial line assembler
// Shared concurrent check forms; each use takes a label, clock and active-low
// reset, then antecedent and consequent.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_ASSEMBLER_CORE_MACROS_SVH
`define SERIAL_LINE_ASSEMBLER_CORE_MACROS_SVH

// same-cycle implication
`define SLAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slac: same-cycle check failed");

// next-cycle implication
`define SLAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slac: next-cycle check failed");

`endif

/* hw/rtl/slac_pkg.sv */
// ----------------------------------------------------------------------------
// slac_pkg
// Types and constants shared by the serial line assembler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package slac_pkg;

    localparam int LINE_MAX  = 64;
    localparam int CNT_W     = $clog2(LINE_MAX);
    localparam int CHAR_W    = 8;
    localparam int WIDE_W    = (CNT_W > CHAR_W) ? CNT_W : CHAR_W;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_RECEIVE    = 2'd0;
    localparam t_cmd CMD_READ       = 2'd1;
    localparam t_cmd CMD_CLEAR_OVF  = 2'd2;
    localparam t_cmd CMD_SOFT_RESET = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0A;

    typedef struct packed {
        logic              is_line_char;
        logic [CHAR_W-1:0] line_char;
        logic              last;
        logic [CHAR_W-1:0] line_length;
        logic              line_ready;
        logic              overflowed;
    } t_result;

    function automatic logic is_eol(input logic [CHAR_W-1:0] c);
        return (c == CHAR_CR) || (c == CHAR_LF);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/serial_line_assembler_core.sv */
// ----------------------------------------------------------------------------
// serial_line_assembler_core
// Collects received bytes into one text line held in a line store and
// streams the line back on request, followed by a terminator transfer.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Signals                       Carries
//  s_axis   in   tvalid tready tdata tuser     command (tuser), rx_char, max_length
//  m_axis   out  tvalid tready tdata tuser     result: char/terminator or status
//                tlast                         tlast marks the final transfer
//
// Receive, clear-overflow, soft-reset and a read with no line ready or a zero
// max_length each return one status transfer; a new command is taken every
// cycle while the output is free and no read is in progress. A read that copies
// n > 0 characters holds s_axis while it starts the first store read, returns
// each character and then the terminator; a terminator-only read sends just that.
// Reset is synchronous, active low; it clears the flags and counters but not
// the line store, which is only ever read where it has been written.
// A stalled m_axis holds its transfer; the sequencer pauses the store reads.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_line_assembler_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [7:0] rx_char, [15:8] max_length
    input  wire logic [slac_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] command
    input  wire logic [1:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [7:0] line_char, [15:8] line_length, [16] line_ready, [17] overflowed
    output logic      [slac_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [0] is_line_char
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tlast
);

    import slac_pkg::*;

    // result register between the sequencer and the master side
    logic    r_m_valid;
    t_result r_m;

    logic    res_free;
    logic    res_load;
    t_result res;

    logic              ram_we;
    logic [CNT_W-1:0]  ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic              ram_re;
    logic [CNT_W-1:0]  ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    assign res_free = !r_m_valid || m_axis_tready;

    slac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_rx_char   (s_axis_tdata[7:0]),
        .i_max_len   (s_axis_tdata[15:8]),
        .i_res_free  (res_free),
        .o_res_load  (res_load),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    slac_line_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_MAX)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_m <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m.is_line_char;
    assign m_axis_tlast  = r_m.last;
    assign m_axis_tdata  = {6'b0, r_m.overflowed, r_m.line_ready,
                            r_m.line_length, r_m.line_char};

endmodule

`default_nettype wire

/* hw/rtl/slac_line_ram.sv */
// ----------------------------------------------------------------------------
// slac_line_ram
// Simple dual-port line store: one write port, one read port with a
// registered output that holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module slac_line_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/slac_ctrl.sv */
// ----------------------------------------------------------------------------
// slac_ctrl
// Line state, command decode and the read sequencer that walks the store.
// ----------------------------------------------------------------------------
`default_nettype none
`include "serial_line_assembler_core_macros.svh"

module slac_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire slac_pkg::t_cmd                i_cmd,
    input  wire logic [slac_pkg::CHAR_W-1:0]   i_rx_char,
    input  wire logic [slac_pkg::CHAR_W-1:0]   i_max_len,
    input  wire logic                          i_res_free,
    output logic                               o_res_load,
    output slac_pkg::t_result                  o_res,
    output logic                               o_ram_we,
    output logic      [slac_pkg::CNT_W-1:0]    o_ram_waddr,
    output logic      [slac_pkg::CHAR_W-1:0]   o_ram_wdata,
    output logic                               o_ram_re,
    output logic      [slac_pkg::CNT_W-1:0]    o_ram_raddr,
    input  wire logic [slac_pkg::CHAR_W-1:0]   i_ram_rdata
);

    import slac_pkg::*;

    typedef logic [WIDE_W-1:0] t_wide;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LINE_MAX - 1);

    logic             r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ready, n_ready;
    logic             r_ovf, n_ovf;
    logic             r_disc, n_disc;
    logic [CNT_W-1:0] r_rd_n, n_rd_n;
    logic [CNT_W-1:0] r_rd_ptr, n_rd_ptr;
    logic             r_dv, n_dv;

    logic             accept;
    logic             status;
    logic             rd_move;
    logic             rd_issue;
    t_wide            cnt_w;
    t_wide            max_w;
    t_wide            len_w;
    t_wide            rd_n_w;
    logic [CNT_W-1:0] rd_len;

    assign o_in_ready = (r_state == ST_IDLE) && i_res_free;
    assign accept     = i_in_valid && o_in_ready;

    // read length: line cut to max_length-1
    assign cnt_w  = t_wide'(r_cnt);
    assign max_w  = t_wide'(i_max_len);
    assign len_w  = (cnt_w >= max_w) ? (max_w - t_wide'(1)) : cnt_w;
    assign rd_len = len_w[CNT_W-1:0];
    assign rd_n_w = t_wide'(r_rd_n);

    assign rd_move  = (r_state == ST_READ) && r_dv && i_res_free;
    assign rd_issue = (r_state == ST_READ) && (r_rd_ptr != r_rd_n) && (!r_dv || rd_move);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ready     = r_ready;
        n_ovf       = r_ovf;
        n_disc      = r_disc;
        n_rd_n      = r_rd_n;
        n_rd_ptr    = r_rd_ptr;
        n_dv        = r_dv;
        status      = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_cnt;
        o_ram_wdata = i_rx_char;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_rd_ptr;
        o_res_load  = 1'b0;
        o_res       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    status = 1'b1;
                    unique case (i_cmd)
                        CMD_RECEIVE: begin
                            priority if (r_ready) begin
                                // line waiting: byte dropped
                            end else if (r_disc) begin
                                if (is_eol(i_rx_char)) begin
                                    n_disc = 1'b0;
                                    n_cnt  = '0;
                                end
                            end else if (is_eol(i_rx_char)) begin
                                if (r_cnt != '0) begin
                                    n_ready = 1'b1;
                                end
                            end else if (r_cnt != CNT_FULL) begin
                                o_ram_we = 1'b1;
                                n_cnt    = r_cnt + CNT_W'(1);
                            end else begin
                                n_ovf  = 1'b1;
                                n_disc = 1'b1;
                                n_cnt  = '0;
                            end
                        end
                        CMD_READ: begin
                            if (r_ready && (i_max_len != '0)) begin
                                status   = 1'b0;
                                n_rd_n   = rd_len;
                                n_rd_ptr = '0;
                                n_dv     = 1'b0;
                                n_cnt    = '0;
                                n_ready  = 1'b0;
                                n_state  = ST_READ;
                            end
                        end
                        CMD_CLEAR_OVF: begin
                            n_ovf = 1'b0;
                        end
                        CMD_SOFT_RESET: begin
                            n_cnt   = '0;
                            n_ready = 1'b0;
                            n_ovf   = 1'b0;
                            n_disc  = 1'b0;
                        end
                    endcase
                end
                if (status) begin
                    o_res_load        = 1'b1;
                    o_res.last        = 1'b1;
                    o_res.line_ready  = n_ready;
                    o_res.overflowed  = n_ovf;
                end
            end
            ST_READ: begin
                if (rd_move) begin
                    o_res_load         = 1'b1;
                    o_res.is_line_char = 1'b1;
                    o_res.line_char    = i_ram_rdata;
                    o_res.line_ready   = r_ready;
                    o_res.overflowed   = r_ovf;
                end else if ((r_rd_ptr == r_rd_n) && !r_dv && i_res_free) begin
                    // terminator item closes the read
                    o_res_load         = 1'b1;
                    o_res.is_line_char = 1'b1;
                    o_res.last         = 1'b1;
                    o_res.line_length  = rd_n_w[CHAR_W-1:0];
                    o_res.line_ready   = r_ready;
                    o_res.overflowed   = r_ovf;
                    n_state            = ST_IDLE;
                end
                if (rd_issue) begin
                    o_ram_re = 1'b1;
                    n_rd_ptr = r_rd_ptr + CNT_W'(1);
                end
                n_dv = rd_issue || (r_dv && !rd_move);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ready  <= 1'b0;
            r_ovf    <= 1'b0;
            r_disc   <= 1'b0;
            r_rd_n   <= '0;
            r_rd_ptr <= '0;
            r_dv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ready  <= n_ready;
            r_ovf    <= n_ovf;
            r_disc   <= n_disc;
            r_rd_n   <= n_rd_n;
            r_rd_ptr <= n_rd_ptr;
            r_dv     <= n_dv;
        end
    end

    `SLAC_ASSERT_IMP(a_disc_empty, i_clk, i_rst_n, r_disc, r_cnt == '0)
    `SLAC_ASSERT_IMP(a_ready_line, i_clk, i_rst_n, r_ready, (r_cnt != '0) && !r_disc)
    `SLAC_ASSERT_IMP(a_ptr_bound, i_clk, i_rst_n, r_state == ST_READ, r_rd_ptr <= r_rd_n)
    `SLAC_ASSERT_NXT(a_last_idle, i_clk, i_rst_n, o_res_load && o_res.last, !r_dv && (r_state == ST_IDLE))

endmodule

`default_nettype wire
